FILE: sv/assert_macros.svh
// Assertion macros used by the drive block's top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on clk, disabled while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Concurrent assertion on clk that also checks during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

FILE: sv/clspd_pkg.sv
// Package with constants, codes and types of the current-limited slew PWM drive.
`timescale 1ns / 1ps

package clspd_pkg;

	// Full-scale duty and the derived per-tick slew step.
	localparam int PWM_FULL_SCALE = 1000;
	localparam int SLEW_DIV       = 25;
	localparam int SLEW           = PWM_FULL_SCALE / SLEW_DIV;

	// Field widths.
	localparam int REQ_W   = 16;
	localparam int CUR_W   = 16;
	localparam int LIMIT_W = 15;
	localparam int DUTY_W  = 10;
	localparam int OFF_W   = 10;
	localparam int DRIVE_W = 11;
	localparam int CFG_W   = 15;

	// Backoff tuning.
	localparam int STEP_DIV      = 5;
	localparam int STEP_MIN      = 5;
	localparam int STEP_MAX      = 100;
	localparam int HOLD_BAND     = 20;
	localparam int DECAY         = 2;
	localparam int STEP_SAT_DIFF = STEP_MAX * STEP_DIV;
	localparam int STEP_W        = 7;
	// Reciprocal of five: x * 205 >> 10 equals x / 5 for x below 512.
	localparam int RECIP_DIV5  = 205;
	localparam int RECIP_SHIFT = 10;
	localparam int DIFF_LO_W   = 9;

	typedef enum logic [0:0] {
		CMD_DRIVE = 1'b0,
		CMD_IDLE  = 1'b1
	} cmd_t;

	typedef enum logic [0:0] {
		CFG_TRQ_ENABLE    = 1'b0,
		CFG_CURRENT_LIMIT = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic               trq_enable;
		logic [LIMIT_W-1:0] current_limit;
	} cfg_t;

endpackage

FILE: sv/clspd_backoff.sv
// Backoff offset update from the current sample and the limit settings.
`timescale 1ns / 1ps

module clspd_backoff import clspd_pkg::*; (
	input  cfg_t                    cfg,
	input  logic signed [CUR_W-1:0] measured_current,
	input  logic [OFF_W-1:0]        backoff,
	output logic [OFF_W-1:0]        backoff_next
);

	logic signed [CUR_W:0]   cur_x;
	logic signed [CUR_W:0]   lim_x;
	logic signed [CUR_W:0]   diff;
	logic                    over;
	logic                    in_band;
	logic                    sat;
	logic [DIFF_LO_W-1:0]    diff_lo;
	logic [DIFF_LO_W+7:0]    prod;
	logic [STEP_W-1:0]       quot;
	logic [STEP_W-1:0]       step;
	logic                    room;

	always_comb begin
		cur_x   = {measured_current[CUR_W-1], measured_current};
		lim_x   = $signed({{(CUR_W+1-LIMIT_W){1'b0}}, cfg.current_limit});
		diff    = cur_x - lim_x;
		over    = diff > $signed((CUR_W+1)'(0));
		in_band = $signed(diff + (CUR_W+1)'(HOLD_BAND)) > $signed((CUR_W+1)'(0));
		sat     = diff[CUR_W-1:0] >= CUR_W'(STEP_SAT_DIFF);

		// Below saturation the excess is under 512, so a reciprocal multiply divides by five.
		diff_lo = diff[DIFF_LO_W-1:0];
		prod    = diff_lo * 8'(RECIP_DIV5);
		quot    = STEP_W'(prod >> RECIP_SHIFT);

		if (sat) begin
			step = STEP_W'(STEP_MAX);
		end else if (quot < STEP_W'(STEP_MIN)) begin
			step = STEP_W'(STEP_MIN);
		end else begin
			step = quot;
		end

		room = ((OFF_W+1)'(backoff) + (OFF_W+1)'(step)) < (OFF_W+1)'(PWM_FULL_SCALE);

		if (!cfg.trq_enable) begin
			backoff_next = '0;
		end else if (over) begin
			backoff_next = room ? backoff + OFF_W'(step) : backoff;
		end else if (in_band) begin
			backoff_next = backoff;
		end else if (backoff > OFF_W'(DECAY)) begin
			backoff_next = backoff - OFF_W'(DECAY);
		end else begin
			backoff_next = backoff;
		end
	end

endmodule

FILE: sv/clspd_slew.sv
// Target formation, full-scale clamp and slew limiting of the drive level.
`timescale 1ns / 1ps

module clspd_slew import clspd_pkg::*; (
	input  logic signed [REQ_W-1:0]   requested_pwm,
	input  logic [OFF_W-1:0]          backoff,
	input  logic signed [DRIVE_W-1:0] drive,
	output logic signed [DRIVE_W-1:0] drive_next
);

	localparam logic signed [REQ_W+1:0]  FsPos = (REQ_W+2)'(PWM_FULL_SCALE);
	localparam logic signed [REQ_W+1:0]  FsNeg = -FsPos;
	localparam logic signed [DRIVE_W:0]  SlewX = (DRIVE_W+1)'(SLEW);

	logic signed [REQ_W+1:0]   req_x;
	logic signed [REQ_W+1:0]   off_x;
	logic signed [REQ_W+1:0]   target;
	logic signed [DRIVE_W-1:0] tgt_c;
	logic signed [DRIVE_W:0]   t_x;
	logic signed [DRIVE_W:0]   d_x;
	logic signed [DRIVE_W:0]   up;
	logic signed [DRIVE_W:0]   dn;

	always_comb begin
		req_x = {{2{requested_pwm[REQ_W-1]}}, requested_pwm};
		off_x = $signed({{(REQ_W+2-OFF_W){1'b0}}, backoff});
		// A zero request is pushed the same way as a negative one.
		if (requested_pwm > $signed(REQ_W'(0))) begin
			target = req_x - off_x;
		end else begin
			target = req_x + off_x;
		end

		if (target > FsPos) begin
			tgt_c = DRIVE_W'(FsPos);
		end else if (target < FsNeg) begin
			tgt_c = DRIVE_W'(FsNeg);
		end else begin
			tgt_c = DRIVE_W'(target);
		end

		t_x = {tgt_c[DRIVE_W-1], tgt_c};
		d_x = {drive[DRIVE_W-1], drive};
		up  = d_x + SlewX;
		dn  = d_x - SlewX;

		if (t_x > up) begin
			drive_next = DRIVE_W'(up);
		end else if (t_x < dn) begin
			drive_next = DRIVE_W'(dn);
		end else begin
			drive_next = tgt_c;
		end
	end

endmodule

FILE: sv/current_limited_slew_pwm_drive.sv
// Top level of the current-limited, slew-limited PWM drive.
//
//   channel   direction  handshake             payload
//   in        input      in_valid / in_stall   cmd, requested_pwm, measured_current
//   out       output     out_valid / out_stall duty_magnitude, clockwise, backoff_offset
//   cfg       input      cfg_we                cfg_index, cfg_data
//
// Every transaction yields one result, held first in the input register and then in the
// result register; one transaction enters per cycle while in_stall is low.
// All arithmetic for a tick sits between the two registers, and the state updates with it.
// Reset clears the backoff offset, the drive level, both settings and all valid flags.
// A stall on the output holds the result; the input register still takes one more
// transaction, and in_stall rises only once both registers are full.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module current_limited_slew_pwm_drive import clspd_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	// Input channel.
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    cmd,
	input  logic signed [REQ_W-1:0] requested_pwm,
	input  logic signed [CUR_W-1:0] measured_current,
	// Result channel.
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [DUTY_W-1:0]       duty_magnitude,
	output logic                    clockwise,
	output logic [OFF_W-1:0]        backoff_offset,
	// Configuration write port.
	input  logic                    cfg_we,
	input  logic                    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data
);

	// Input register stage.
	logic                    valid_s1;
	cmd_t                    cmd_s1;
	logic signed [REQ_W-1:0] req_s1;
	logic signed [CUR_W-1:0] cur_s1;

	// Persistent state and settings.
	logic [OFF_W-1:0]          backoff_q;
	logic signed [DRIVE_W-1:0] drive_q;
	cfg_t                      cfg_q;

	// Result register stage.
	logic              valid_s2;
	logic [DUTY_W-1:0] duty_s2;
	logic              cw_s2;
	logic [OFF_W-1:0]  off_s2;

	logic                      s2_free;
	logic                      adv;
	logic                      in_take;
	logic                      idle;
	logic [OFF_W-1:0]          backoff_next;
	logic signed [DRIVE_W-1:0] drive_next;
	logic [OFF_W-1:0]          backoff_new;
	logic signed [DRIVE_W-1:0] drive_new;
	logic [DRIVE_W-1:0]        drive_abs;

	// The result register empties or is taken this cycle, so stage one may move on.
	assign s2_free  = !valid_s2 || !out_stall;
	assign adv      = valid_s1 && s2_free;
	assign in_stall = valid_s1 && !s2_free;
	assign in_take  = in_valid && !in_stall;
	assign idle     = (cmd_s1 == CMD_IDLE);

	clspd_backoff u_backoff (
		.cfg              (cfg_q),
		.measured_current (cur_s1),
		.backoff          (backoff_q),
		.backoff_next     (backoff_next)
	);

	clspd_slew u_slew (
		.requested_pwm (req_s1),
		.backoff       (backoff_next),
		.drive         (drive_q),
		.drive_next    (drive_next)
	);

	// An idle command drops both the drive and the offset to zero.
	always_comb begin
		backoff_new = idle ? '0 : backoff_next;
		drive_new   = idle ? '0 : drive_next;
		drive_abs   = drive_new[DRIVE_W-1] ? DRIVE_W'(-drive_new) : DRIVE_W'(drive_new);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			cmd_s1 <= cmd_t'(cmd);
			req_s1 <= requested_pwm;
			cur_s1 <= measured_current;
		end
	end

	// State advances once per transaction; idle also leaves torque mode and clears the limit.
	// The user writes only while no transaction is in flight; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			backoff_q <= '0;
			drive_q   <= '0;
			cfg_q     <= '0;
		end else begin
			if (adv) begin
				backoff_q <= backoff_new;
				drive_q   <= drive_new;
			end
			if (adv && idle) begin
				cfg_q <= '0;
			end else if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_TRQ_ENABLE: begin
						cfg_q.trq_enable <= cfg_data[0];
					end
					CFG_CURRENT_LIMIT: begin
						cfg_q.current_limit <= cfg_data[LIMIT_W-1:0];
					end
					default: begin
						cfg_q <= cfg_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			duty_s2 <= drive_abs[DUTY_W-1:0];
			cw_s2   <= !drive_new[DRIVE_W-1];
			off_s2  <= backoff_new;
		end
	end

	assign out_valid      = valid_s2;
	assign duty_magnitude = duty_s2;
	assign clockwise      = cw_s2;
	assign backoff_offset = off_s2;

	`ASSERT_ALWAYS(a_backoff_range, !arst_n || (backoff_q < OFF_W'(PWM_FULL_SCALE)),
		"backoff out of range")
	`ASSERT_CLK(a_idle_clears,
		adv && idle |=> backoff_q == '0 && drive_q == '0 && !cfg_q.trq_enable,
		"idle did not clear state")
	`ASSERT_CLK(a_stall_full, in_stall |-> valid_s1 && valid_s2 && out_stall, "input stalled with room")
	`ASSERT_CLK(a_adv_result, adv |=> valid_s2, "advanced transaction lost")
	`ASSERT_CLK(a_state_hold, !adv |=> $stable(drive_q) && $stable(backoff_q),
		"state moved without a transaction")

endmodule
